// ===== design/qwot_pkg.sv =====
package qwot_pkg;

  localparam int CHANNELS = 4;

  // Restoring divider: dividend, divisor and step counter widths.
  localparam int DIV_W     = 80;
  localparam int DIVR_W    = 40;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam logic [15:0] RPM_SCALE = 16'd60000;
  localparam logic [8:0]  PI_NUM    = 9'd355;
  localparam logic [6:0]  PI_DEN    = 7'd113;
  localparam logic [15:0] DEG_NUM   = 16'd57296;
  localparam logic [6:0]  DEG_DEN   = 7'd100;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_INIT   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_COUNTER_PERIOD  = 3'd0,
    REG_COUNTS_PER_REV  = 3'd1,
    REG_SPEED_PERIOD_MS = 3'd2,
    REG_POLARITY_MASK   = 3'd3,
    REG_WHEEL_DIA_MM    = 3'd4,
    REG_CAL_NUM         = 3'd5,
    REG_CAL_DEN         = 3'd6,
    REG_TRACK_WIDTH     = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_SAMPLE,
    LOP_CLEAR
  } lane_op_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [15:0] raw_count_0;
    logic [15:0] raw_count_1;
    logic [15:0] raw_count_2;
    logic [15:0] raw_count_3;
    logic [3:0]  clear_mask;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position_0;
    logic signed [31:0] position_1;
    logic signed [31:0] position_2;
    logic signed [31:0] position_3;
    logic signed [15:0] speed_rpm_0;
    logic signed [15:0] speed_rpm_1;
    logic signed [15:0] speed_rpm_2;
    logic signed [15:0] speed_rpm_3;
    logic signed [31:0] avg_distance_mm;
    logic signed [31:0] left_distance_mm;
    logic signed [31:0] right_distance_mm;
    logic signed [31:0] rotation_deg10;
  } out_t;

  typedef struct packed {
    lane_op_e    op;
    logic        upd;
    logic        pol;
    logic [15:0] raw;
    logic [31:0] elapsed;
  } lane_cmd_t;

  typedef struct packed {
    logic [15:0] dia;
    logic [15:0] cal_num;
    logic [15:0] cal_den;
    logic [15:0] cpr;
    logic [15:0] track;
  } merge_cfg_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_D1GO, L_D1WAIT, L_D2GO, L_D2WAIT, L_DONE
  } lane_state_e;

  typedef enum logic [3:0] {
    M_IDLE, M_PREP, M_CONST, M_MLO, M_MHI, M_MSUM, M_DGO, M_DWAIT,
    M_RMUL, M_R1GO, M_R1WAIT, M_DONE
  } merge_state_e;

  typedef enum logic [2:0] {
    T_IDLE, T_LSTART, T_LWAIT, T_MSTART, T_MWAIT, T_OUT
  } top_state_e;

endpackage

// ===== design/qwot_div.sv =====
module qwot_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [qwot_pkg::DIV_W-1:0]    dividend_i,
  input  logic [qwot_pkg::DIVR_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [qwot_pkg::DIV_W-1:0]    quotient_o
);

  logic                            busy_q, done_q;
  logic [qwot_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [qwot_pkg::DIVR_W-1:0]     rem_q, dvs_q, rem_d;
  logic [qwot_pkg::DIV_W-1:0]      quo_q;
  logic [qwot_pkg::DIVR_W:0]       rem_sh, rem_nx;
  logic                            ge;

  // One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
  always_comb begin
    rem_sh = {rem_q, quo_q[qwot_pkg::DIV_W-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    rem_d  = rem_nx[qwot_pkg::DIVR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == qwot_pkg::DIV_CNT_W'(qwot_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[qwot_pkg::DIV_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/qwot_lane.sv =====
module qwot_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  qwot_pkg::lane_cmd_t     cmd_i,
  input  logic [16:0]             period_i,
  input  logic [15:0]             cpr_i,
  output logic                    done_o,
  output logic [31:0]             position_o,
  output logic [15:0]             speed_o
);

  qwot_pkg::lane_state_e state_q, state_d;
  logic [31:0] pos_q, snap_q;
  logic [15:0] last_q, spd_q;
  logic        neg_q;
  logic [47:0] prod_q;
  logic [31:0] elapsed_q;

  logic signed [18:0] delta, dfold, half_s, per_s;
  logic [31:0] pos_samp, dpos, mag;
  logic        div_start, div_done;
  logic [qwot_pkg::DIV_W-1:0]  div_a, div_q;
  logic [qwot_pkg::DIVR_W-1:0] div_b;

  // Fold the raw difference into [-floor(period/2), floor(period/2)] to undo counter wraps.
  always_comb begin
    half_s = $signed({3'b000, period_i[16:1]});
    per_s  = $signed({2'b00, period_i});
    delta  = $signed({3'b000, cmd_i.raw}) - $signed({3'b000, last_q});
    if (delta > half_s) begin
      dfold = delta - per_s;
    end else if (delta < -half_s) begin
      dfold = delta + per_s;
    end else begin
      dfold = delta;
    end
    if (cmd_i.pol) begin
      dfold = -dfold;
    end
    pos_samp = pos_q + {{13{dfold[18]}}, dfold};
    dpos     = pos_q - snap_q;
    mag      = dpos[31] ? (~dpos + 32'd1) : dpos;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      qwot_pkg::L_IDLE: begin
        if (start_i) begin
          state_d = (cmd_i.op == qwot_pkg::LOP_SAMPLE && cmd_i.upd) ?
                    qwot_pkg::L_MUL : qwot_pkg::L_DONE;
        end
      end
      qwot_pkg::L_MUL:    state_d = qwot_pkg::L_D1GO;
      qwot_pkg::L_D1GO:   state_d = qwot_pkg::L_D1WAIT;
      qwot_pkg::L_D1WAIT: if (div_done) state_d = qwot_pkg::L_D2GO;
      qwot_pkg::L_D2GO:   state_d = qwot_pkg::L_D2WAIT;
      qwot_pkg::L_D2WAIT: if (div_done) state_d = qwot_pkg::L_DONE;
      qwot_pkg::L_DONE:   state_d = qwot_pkg::L_IDLE;
      default:            state_d = qwot_pkg::L_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state_q == qwot_pkg::L_D1GO) || (state_q == qwot_pkg::L_D2GO);
    done_o    = (state_q == qwot_pkg::L_DONE);
    if (state_q == qwot_pkg::L_D2GO) begin
      div_a = div_q;
      div_b = {8'd0, elapsed_q};
    end else begin
      div_a = {32'd0, prod_q};
      div_b = {24'd0, cpr_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qwot_pkg::L_IDLE;
      pos_q   <= '0;
      snap_q  <= '0;
      last_q  <= '0;
      spd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == qwot_pkg::L_IDLE && start_i) begin
        if (cmd_i.op == qwot_pkg::LOP_CLEAR) begin
          pos_q  <= '0;
          snap_q <= '0;
          spd_q  <= '0;
          last_q <= cmd_i.raw;
        end else if (cmd_i.op == qwot_pkg::LOP_SAMPLE) begin
          pos_q  <= pos_samp;
          last_q <= cmd_i.raw;
        end
      end
      if (state_q == qwot_pkg::L_D2WAIT && div_done) begin
        snap_q <= pos_q;
        if (!neg_q) begin
          spd_q <= (div_q > qwot_pkg::DIV_W'(32767)) ? 16'h7FFF : div_q[15:0];
        end else begin
          spd_q <= (div_q > qwot_pkg::DIV_W'(32768)) ? 16'h8000 :
                   16'(~div_q[15:0] + 16'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == qwot_pkg::L_IDLE && start_i) begin
      elapsed_q <= cmd_i.elapsed;
    end
    if (state_q == qwot_pkg::L_MUL) begin
      neg_q  <= dpos[31];
      prod_q <= {16'd0, mag} * {32'd0, qwot_pkg::RPM_SCALE};
    end
  end

  qwot_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign position_o = pos_q;
  assign speed_o    = spd_q;

endmodule

// ===== design/qwot_merge.sv =====
module qwot_merge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [3:0][31:0]      pos_i,
  input  qwot_pkg::merge_cfg_t  cfg_i,
  output logic                  done_o,
  output logic [31:0]           avg_o,
  output logic [31:0]           left_o,
  output logic [31:0]           right_o,
  output logic [31:0]           rot_o
);

  qwot_pkg::merge_state_e state_q, state_d;
  logic [1:0]  sel_q;
  logic [31:0] mag_q [3];
  logic        neg_q [3];
  logic [31:0] res_q [3];
  logic [31:0] rot_q;
  logic [24:0] a1_q;
  logic [22:0] d1_q;
  logic [40:0] a_q;
  logic [38:0] den_q;
  logic [63:0] plo_q;
  logic [40:0] phi_q;
  logic        rneg_q;
  logic [qwot_pkg::DIV_W-1:0]  div_a_q, div_q;
  logic [qwot_pkg::DIVR_W-1:0] div_b_q;
  logic        div_start, div_done;

  logic signed [33:0] s4, t4, m4;
  logic signed [32:0] sl, sr, tl, tr, ml, mr, diff;
  logic [32:0] rmag;
  logic [31:0] qcap;

  // Means truncate toward zero, so negative sums get a bias before the shift.
  always_comb begin
    s4 = $signed({{2{pos_i[0][31]}}, pos_i[0]}) + $signed({{2{pos_i[1][31]}}, pos_i[1]})
       + $signed({{2{pos_i[2][31]}}, pos_i[2]}) + $signed({{2{pos_i[3][31]}}, pos_i[3]});
    sl = $signed({pos_i[0][31], pos_i[0]}) + $signed({pos_i[1][31], pos_i[1]});
    sr = $signed({pos_i[2][31], pos_i[2]}) + $signed({pos_i[3][31], pos_i[3]});
    t4 = s4 + $signed({32'd0, s4[33], s4[33]});
    tl = sl + $signed({32'd0, sl[32]});
    tr = sr + $signed({32'd0, sr[32]});
    m4 = t4 >>> 2;
    ml = tl >>> 1;
    mr = tr >>> 1;
    diff = $signed({res_q[2][31], res_q[2]}) - $signed({res_q[1][31], res_q[1]});
    rmag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  // Cap the quotient magnitude to the signed 32-bit range and restore its sign.
  function automatic logic [31:0] cap_sign(input logic [qwot_pkg::DIV_W-1:0] q,
                                           input logic neg);
    logic [31:0] m;
    begin
      if (neg) begin
        m = (q > qwot_pkg::DIV_W'(32'h8000_0000)) ? 32'h8000_0000 : q[31:0];
        cap_sign = ~m + 32'd1;
      end else begin
        cap_sign = (q > qwot_pkg::DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
      end
    end
  endfunction

  assign qcap = cap_sign(div_q, (state_q == qwot_pkg::M_R1WAIT) ? rneg_q : neg_q[sel_q]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      qwot_pkg::M_IDLE:  if (start_i) state_d = qwot_pkg::M_PREP;
      qwot_pkg::M_PREP:  state_d = qwot_pkg::M_CONST;
      qwot_pkg::M_CONST: state_d = qwot_pkg::M_MLO;
      qwot_pkg::M_MLO:   state_d = qwot_pkg::M_MHI;
      qwot_pkg::M_MHI:   state_d = qwot_pkg::M_MSUM;
      qwot_pkg::M_MSUM:  state_d = qwot_pkg::M_DGO;
      qwot_pkg::M_DGO:   state_d = qwot_pkg::M_DWAIT;
      qwot_pkg::M_DWAIT: begin
        if (div_done) begin
          if (sel_q != 2'd2) begin
            state_d = qwot_pkg::M_MLO;
          end else if (cfg_i.track == 16'd0) begin
            state_d = qwot_pkg::M_DONE;
          end else begin
            state_d = qwot_pkg::M_RMUL;
          end
        end
      end
      qwot_pkg::M_RMUL:   state_d = qwot_pkg::M_R1GO;
      qwot_pkg::M_R1GO:   state_d = qwot_pkg::M_R1WAIT;
      qwot_pkg::M_R1WAIT: if (div_done) state_d = qwot_pkg::M_DONE;
      qwot_pkg::M_DONE:   state_d = qwot_pkg::M_IDLE;
      default:            state_d = qwot_pkg::M_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state_q == qwot_pkg::M_DGO) || (state_q == qwot_pkg::M_R1GO);
    done_o    = (state_q == qwot_pkg::M_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qwot_pkg::M_IDLE;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == qwot_pkg::M_PREP) begin
        sel_q <= '0;
      end else if (state_q == qwot_pkg::M_DWAIT && div_done && sel_q != 2'd2) begin
        sel_q <= sel_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      qwot_pkg::M_PREP: begin
        neg_q[0] <= m4[33];
        neg_q[1] <= ml[32];
        neg_q[2] <= mr[32];
        mag_q[0] <= m4[33] ? 32'(-m4) : m4[31:0];
        mag_q[1] <= ml[32] ? 32'(-ml) : ml[31:0];
        mag_q[2] <= mr[32] ? 32'(-mr) : mr[31:0];
        a1_q <= {16'd0, qwot_pkg::PI_NUM} * {9'd0, cfg_i.dia};
        d1_q <= {16'd0, qwot_pkg::PI_DEN} * {7'd0, cfg_i.cpr};
      end
      qwot_pkg::M_CONST: begin
        a_q   <= {16'd0, a1_q} * {25'd0, cfg_i.cal_num};
        den_q <= {16'd0, d1_q} * {23'd0, cfg_i.cal_den};
      end
      qwot_pkg::M_MLO: plo_q <= {32'd0, mag_q[sel_q]} * {32'd0, a_q[31:0]};
      qwot_pkg::M_MHI: phi_q <= {9'd0, mag_q[sel_q]} * {32'd0, a_q[40:32]};
      qwot_pkg::M_MSUM: begin
        div_a_q <= {16'd0, plo_q} + {7'd0, phi_q, 32'd0};
        div_b_q <= {1'b0, den_q};
      end
      qwot_pkg::M_DWAIT: begin
        if (div_done) begin
          res_q[sel_q] <= qcap;
          if (sel_q == 2'd2 && cfg_i.track == 16'd0) begin
            rot_q <= '0;
          end
        end
      end
      // One division by track times 100 truncates exactly as the two successive ones.
      qwot_pkg::M_RMUL: begin
        rneg_q  <= diff[32];
        div_a_q <= {31'd0, 49'({16'd0, rmag} * {33'd0, qwot_pkg::DEG_NUM})};
        div_b_q <= {17'd0, ({7'd0, cfg_i.track} * {16'd0, qwot_pkg::DEG_DEN})};
      end
      qwot_pkg::M_R1WAIT: if (div_done) rot_q <= qcap;
      default: begin
      end
    endcase
  end

  qwot_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign avg_o   = res_q[0];
  assign left_o  = res_q[1];
  assign right_o = res_q[2];
  assign rot_o   = rot_q;

endmodule

// ===== design/quad_wheel_odometry_tracker_top.sv =====
// Four-channel wheel odometry. Each request on the input channel is a sample of
// the four raw counters, a clear of selected channels or an init; each yields
// exactly one result request carrying positions, rpm, distances and rotation.
// Configuration registers are written through the cfg channel while idle.
// One request is processed at a time. Four channel lanes first update their
// counts; when the speed period has elapsed each lane also runs two 80-step
// divisions for its rpm. The merging stage then runs three 80-step divisions
// on its shared divider for the three distances and, when the track width is
// nonzero, a fourth for the rotation. The next request can be taken in the
// cycle after the result is loaded; in_stall_o stays high from acceptance
// until then. The result sits in an output register: if the receiver stalls,
// the next request is still taken and processed, and its result waits until
// the previous one has been taken. Reset clears all counts, rpm and the init
// flag and restores the register defaults; samples are ignored until an init.
module quad_wheel_odometry_tracker_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qwot_pkg::in_t     in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qwot_pkg::out_t    out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  qwot_pkg::top_state_e state_q, state_d;

  logic [16:0] period_q;
  logic [15:0] cpr_q, spd_per_q, dia_q, cal_num_q, cal_den_q, track_q;
  logic [3:0]  pol_q;
  logic        ready_q;
  logic [31:0] last_time_q;
  logic        out_valid_q;
  qwot_pkg::out_t out_q;

  qwot_pkg::lane_cmd_t [qwot_pkg::CHANNELS-1:0] cmd_q;
  logic [qwot_pkg::CHANNELS-1:0]        lane_done;
  logic [qwot_pkg::CHANNELS-1:0][31:0]  lane_pos;
  logic [qwot_pkg::CHANNELS-1:0][15:0]  lane_spd;
  logic [qwot_pkg::CHANNELS-1:0][15:0]  raw;

  logic        accept, upd, lane_start, merge_start, merge_done, load_out;
  logic [31:0] elapsed;
  logic [15:0] cpr_nz, cal_den_nz;
  logic [31:0] avg, left, right, rot;
  qwot_pkg::merge_cfg_t mcfg;

  assign accept     = in_valid_i && !in_stall_o;
  assign raw        = {in_i.raw_count_3, in_i.raw_count_2, in_i.raw_count_1,
                       in_i.raw_count_0};
  assign elapsed    = in_i.now_ms - last_time_q;
  assign upd        = (in_i.mode == qwot_pkg::MODE_SAMPLE) && ready_q &&
                      (elapsed >= {16'd0, spd_per_q}) && (elapsed != 32'd0);
  assign cpr_nz     = (cpr_q == 16'd0) ? 16'd1 : cpr_q;
  assign cal_den_nz = (cal_den_q == 16'd0) ? 16'd1 : cal_den_q;
  assign mcfg       = '{dia: dia_q, cal_num: cal_num_q, cal_den: cal_den_nz,
                        cpr: cpr_nz, track: track_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      qwot_pkg::T_IDLE:   if (accept) state_d = qwot_pkg::T_LSTART;
      qwot_pkg::T_LSTART: state_d = qwot_pkg::T_LWAIT;
      qwot_pkg::T_LWAIT:  if (&lane_done) state_d = qwot_pkg::T_MSTART;
      qwot_pkg::T_MSTART: state_d = qwot_pkg::T_MWAIT;
      qwot_pkg::T_MWAIT:  if (merge_done) state_d = qwot_pkg::T_OUT;
      qwot_pkg::T_OUT:    if (load_out) state_d = qwot_pkg::T_IDLE;
      default:            state_d = qwot_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != qwot_pkg::T_IDLE);
    cfg_ready_o = (state_q == qwot_pkg::T_IDLE);
    lane_start  = (state_q == qwot_pkg::T_LSTART);
    merge_start = (state_q == qwot_pkg::T_MSTART);
    load_out    = (state_q == qwot_pkg::T_OUT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qwot_pkg::T_IDLE;
      period_q    <= 17'd3600;
      cpr_q       <= 16'd1024;
      spd_per_q   <= 16'd20;
      pol_q       <= 4'd0;
      dia_q       <= 16'd65;
      cal_num_q   <= 16'd1;
      cal_den_q   <= 16'd1;
      track_q     <= 16'd200;
      ready_q     <= 1'b0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (qwot_pkg::reg_e'(cfg_index_i))
          qwot_pkg::REG_COUNTER_PERIOD:  period_q  <= cfg_data_i[16:0];
          qwot_pkg::REG_COUNTS_PER_REV:  cpr_q     <= cfg_data_i[15:0];
          qwot_pkg::REG_SPEED_PERIOD_MS: spd_per_q <= cfg_data_i[15:0];
          qwot_pkg::REG_POLARITY_MASK:   pol_q     <= cfg_data_i[3:0];
          qwot_pkg::REG_WHEEL_DIA_MM:    dia_q     <= cfg_data_i[15:0];
          qwot_pkg::REG_CAL_NUM:         cal_num_q <= cfg_data_i[15:0];
          qwot_pkg::REG_CAL_DEN:         cal_den_q <= cfg_data_i[15:0];
          qwot_pkg::REG_TRACK_WIDTH:     track_q   <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (in_i.mode == qwot_pkg::MODE_INIT) begin
          ready_q     <= 1'b1;
          last_time_q <= in_i.now_ms;
        end else if (upd) begin
          last_time_q <= in_i.now_ms;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int m = 0; m < qwot_pkg::CHANNELS; m++) begin
        cmd_q[m].raw     <= raw[m];
        cmd_q[m].pol     <= pol_q[m];
        cmd_q[m].upd     <= upd;
        cmd_q[m].elapsed <= elapsed;
        case (qwot_pkg::mode_e'(in_i.mode))
          qwot_pkg::MODE_SAMPLE: cmd_q[m].op <= ready_q ? qwot_pkg::LOP_SAMPLE :
                                                          qwot_pkg::LOP_NONE;
          qwot_pkg::MODE_CLEAR:  cmd_q[m].op <= in_i.clear_mask[m] ? qwot_pkg::LOP_CLEAR :
                                                                     qwot_pkg::LOP_NONE;
          qwot_pkg::MODE_INIT:   cmd_q[m].op <= qwot_pkg::LOP_CLEAR;
          default:               cmd_q[m].op <= qwot_pkg::LOP_NONE;
        endcase
      end
    end
    if (load_out) begin
      out_q.position_0        <= $signed(lane_pos[0]);
      out_q.position_1        <= $signed(lane_pos[1]);
      out_q.position_2        <= $signed(lane_pos[2]);
      out_q.position_3        <= $signed(lane_pos[3]);
      out_q.speed_rpm_0       <= $signed(lane_spd[0]);
      out_q.speed_rpm_1       <= $signed(lane_spd[1]);
      out_q.speed_rpm_2       <= $signed(lane_spd[2]);
      out_q.speed_rpm_3       <= $signed(lane_spd[3]);
      out_q.avg_distance_mm   <= $signed(avg);
      out_q.left_distance_mm  <= $signed(left);
      out_q.right_distance_mm <= $signed(right);
      out_q.rotation_deg10    <= $signed(rot);
    end
  end

  for (genvar g = 0; g < qwot_pkg::CHANNELS; g++) begin : g_lane
    qwot_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (lane_start),
      .cmd_i      (cmd_q[g]),
      .period_i   (period_q),
      .cpr_i      (cpr_nz),
      .done_o     (lane_done[g]),
      .position_o (lane_pos[g]),
      .speed_o    (lane_spd[g])
    );
  end

  qwot_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (merge_start),
    .pos_i   (lane_pos),
    .cfg_i   (mcfg),
    .done_o  (merge_done),
    .avg_o   (avg),
    .left_o  (left),
    .right_o (right),
    .rot_o   (rot)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
